// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the descriptor scanner.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define UBDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define UBDS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UBDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ubds_pkg.sv -----
// Package of the bulk-only descriptor scanner: payload types, status codes,
// descriptor constants and the walk summary struct. No dependencies.
package ubds_pkg;

    localparam int UBDS_BUFFER_BYTES = 256;
    localparam logic [9:0] CAP_RESET = 10'd64;

    // descriptor codes
    localparam logic [7:0] DT_INTERFACE   = 8'h04;
    localparam logic [7:0] DT_ENDPOINT    = 8'h05;
    localparam logic [7:0] MSC_CLASS      = 8'h08;
    localparam logic [7:0] MSC_SUBCLASS   = 8'h06;
    localparam logic [7:0] MSC_PROTO_BOT  = 8'h50;
    localparam logic [7:0] EP_DIR_IN      = 8'h80;
    localparam logic [7:0] EP_NUM_MASK    = 8'h0F;
    localparam logic [7:0] EP_XFER_MASK   = 8'h03;
    localparam logic [7:0] EP_XFER_BULK   = 8'h02;
    localparam logic [7:0] REC_MIN_LEN    = 8'd2;
    localparam logic [7:0] IF_MIN_LEN     = 8'd9;
    localparam logic [7:0] EP_MIN_LEN     = 8'd7;
    localparam logic [7:0] HDR_MIN_TOTAL  = 8'd9;

    typedef enum logic [1:0] {
        ST_FOUND        = 2'd0,
        ST_NO_HEADER    = 2'd1,
        ST_NO_INTERFACE = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } desc_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] bulk_in_endpoint;
        logic [3:0] bulk_out_endpoint;
        logic [9:0] bulk_in_max_packet;
        logic [9:0] bulk_out_max_packet;
        logic [7:0] config_value;
    } result_t;

    typedef struct packed {
        logic [9:0] max_packet_cap;
    } cfg_t;

    // scan state after the current byte, handed from the walker to the top
    typedef struct packed {
        logic        header_ok;
        logic        found;
        logic [3:0]  in_ep;
        logic [3:0]  out_ep;
        logic [15:0] in_pkt;
        logic [15:0] out_pkt;
        logic [7:0]  config_value;
    } walk_sum_t;

endpackage

// ----- rtl/ubds_chan_if.sv -----
// Valid/ready channel carrying one payload struct per transfer.
// Payload type is chosen at instantiation, normally from ubds_pkg.
interface ubds_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/ubds_walk.sv -----
// Record walker of the descriptor scanner: offset, header, record and
// endpoint state, updated once per accepted byte. Depends on ubds_pkg.
module ubds_walk #(
    parameter int BUFFER_BYTES = ubds_pkg::UBDS_BUFFER_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  ubds_pkg::desc_t     desc_in,
    output ubds_pkg::walk_sum_t sum
);
    import ubds_pkg::*;

    localparam int OFF_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(BUFFER_BYTES);
    localparam logic [15:0] BUF16 = 16'(BUFFER_BYTES);

    logic [OFF_W-1:0] off_reg, off_next;
    logic [7:0]       tot_lo_reg, tot_lo_next;
    logic [OFF_W-1:0] total_reg, total_next;
    logic [7:0]       rel_reg, rel_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       type_reg, type_next;
    logic             stopped_reg, stopped_next;
    logic             tgt_reg, tgt_next;
    logic             found_reg, found_next;
    logic [7:0]       held_reg [4];
    logic [7:0]       held_next [4];
    logic [3:0]       in_ep_reg, in_ep_next;
    logic [3:0]       out_ep_reg, out_ep_next;
    logic [15:0]      in_pkt_reg, in_pkt_next;
    logic [15:0]      out_pkt_reg, out_pkt_next;
    logic [7:0]       cfg_reg, cfg_next;

    logic [7:0]  b;
    logic [15:0] raw_total;
    logic        walk_on;
    logic [7:0]  typ;
    logic        finish;
    logic [15:0] ep_size;

    always_comb
    begin
        b            = desc_in.data_byte;
        off_next     = (off_reg == OFF_MAX) ? off_reg : off_reg + 1'b1;
        tot_lo_next  = tot_lo_reg;
        total_next   = total_reg;
        cfg_next     = cfg_reg;
        rel_next     = rel_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        stopped_next = stopped_reg;
        tgt_next     = tgt_reg;
        found_next   = found_reg;
        held_next    = held_reg;
        in_ep_next   = in_ep_reg;
        out_ep_next  = out_ep_reg;
        in_pkt_next  = in_pkt_reg;
        out_pkt_next = out_pkt_reg;
        raw_total    = {b, tot_lo_reg};
        typ          = (rel_reg == 8'd1) ? b : type_reg;
        finish       = 1'b0;
        ep_size      = {held_reg[3], held_reg[2]};

        // header fields
        if (off_reg == OFF_W'(2))
        begin
            tot_lo_next = b;
        end
        if (off_reg == OFF_W'(3))
        begin
            total_next = (raw_total > BUF16) ? OFF_MAX : raw_total[OFF_W-1:0];
        end
        if (off_reg == OFF_W'(5))
        begin
            cfg_next = b;
        end

        // bytes past the total length drop out of the walk for good
        walk_on = !stopped_reg && !(off_reg > OFF_W'(3) && off_reg >= total_reg);

        if (walk_on)
        begin
            if (rel_reg == 8'd0)
            begin
                len_next = b;
                rel_next = 8'd1;
                if (b < REC_MIN_LEN)
                begin
                    stopped_next = 1'b1;
                end
            end
            else
            begin
                if (rel_reg == 8'd1)
                begin
                    type_next = b;
                end
                if (typ == DT_INTERFACE && rel_reg >= 8'd5 && rel_reg <= 8'd7)
                begin
                    held_next[2'(rel_reg - 8'd5)] = b;
                end
                else if (typ == DT_ENDPOINT && rel_reg >= 8'd2 && rel_reg <= 8'd5)
                begin
                    held_next[2'(rel_reg - 8'd2)] = b;
                end
                finish   = ({1'b0, rel_reg} + 9'd1) == {1'b0, len_reg};
                rel_next = finish ? 8'd0 : rel_reg + 8'd1;
            end
        end

        // close the record: interface opens/closes a target, bulk endpoint fills in
        if (finish)
        begin
            if (typ == DT_INTERFACE && len_reg >= IF_MIN_LEN)
            begin
                tgt_next = held_reg[0] == MSC_CLASS && held_reg[1] == MSC_SUBCLASS &&
                           held_reg[2] == MSC_PROTO_BOT;
            end
            else if (typ == DT_ENDPOINT && len_reg >= EP_MIN_LEN && tgt_reg)
            begin
                if ((held_reg[1] & EP_XFER_MASK) == EP_XFER_BULK)
                begin
                    if ((held_reg[0] & EP_DIR_IN) != 8'd0)
                    begin
                        in_ep_next  = held_reg[0][3:0];
                        in_pkt_next = ep_size;
                    end
                    else
                    begin
                        out_ep_next  = held_reg[0][3:0];
                        out_pkt_next = ep_size;
                    end
                end
                if (in_ep_next != 4'd0 && out_ep_next != 4'd0)
                begin
                    found_next = 1'b1;
                end
            end
        end

        sum.header_ok    = off_next >= OFF_W'(4) && total_next >= OFF_W'(HDR_MIN_TOTAL);
        sum.found        = found_next && in_ep_next != 4'd0 && out_ep_next != 4'd0;
        sum.in_ep        = in_ep_next;
        sum.out_ep       = out_ep_next;
        sum.in_pkt       = in_pkt_next;
        sum.out_pkt      = out_pkt_next;
        sum.config_value = cfg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg     <= '0;
            tot_lo_reg  <= '0;
            total_reg   <= '0;
            rel_reg     <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            stopped_reg <= 1'b0;
            tgt_reg     <= 1'b0;
            found_reg   <= 1'b0;
            held_reg    <= '{default: '0};
            in_ep_reg   <= '0;
            out_ep_reg  <= '0;
            in_pkt_reg  <= '0;
            out_pkt_reg <= '0;
            cfg_reg     <= '0;
        end
        else if (take)
        begin
            if (desc_in.last_byte)
            begin
                // descriptor done: back to the start for the next one
                off_reg     <= '0;
                tot_lo_reg  <= '0;
                total_reg   <= '0;
                rel_reg     <= '0;
                len_reg     <= '0;
                type_reg    <= '0;
                stopped_reg <= 1'b0;
                tgt_reg     <= 1'b0;
                found_reg   <= 1'b0;
                held_reg    <= '{default: '0};
                in_ep_reg   <= '0;
                out_ep_reg  <= '0;
                in_pkt_reg  <= '0;
                out_pkt_reg <= '0;
                cfg_reg     <= '0;
            end
            else
            begin
                off_reg     <= off_next;
                tot_lo_reg  <= tot_lo_next;
                total_reg   <= total_next;
                rel_reg     <= rel_next;
                len_reg     <= len_next;
                type_reg    <= type_next;
                stopped_reg <= stopped_next;
                tgt_reg     <= tgt_next;
                found_reg   <= found_next;
                held_reg    <= held_next;
                in_ep_reg   <= in_ep_next;
                out_ep_reg  <= out_ep_next;
                in_pkt_reg  <= in_pkt_next;
                out_pkt_reg <= out_pkt_next;
                cfg_reg     <= cfg_next;
            end
        end
    end

endmodule

// ----- rtl/usb_bulk_only_descriptor_scan.sv -----
// Top level of the bulk-only descriptor scanner: cap register, status and
// clamp logic, result register. Depends on ubds_pkg, ubds_chan_if, ubds_walk.
//
//  channel  dir  payload                                     transfer
//  desc     in   data_byte, last_byte                        valid & ready
//  result   out  status, endpoints, max packets, config      valid & ready
//  cfg      in   max_packet_cap                              valid & ready
//
// One descriptor byte per cycle unless desc stalls; a result appears in the
// cycle after the byte with last_byte is taken, set by the result register.
// Reset (rst_n, asynchronous, active low) clears the scan and loads the cap
// with 64. cfg is always ready. desc stalls only while a result is held and
// result.ready is low; the next byte is taken in the cycle the result leaves.
`include "assert_macros.svh"

module usb_bulk_only_descriptor_scan #(
    parameter int BUFFER_BYTES = ubds_pkg::UBDS_BUFFER_BYTES
) (
    input  logic clk,
    input  logic rst_n,
    ubds_chan_if.sink   desc,
    ubds_chan_if.source result,
    ubds_chan_if.sink   cfg
);
    import ubds_pkg::*;

    logic            take;
    walk_sum_t       sum;
    logic [9:0]      cap_reg;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;

    // hold the next byte only while a result waits to be taken
    assign desc.ready = !out_valid_reg || result.ready;
    assign take       = desc.valid && desc.ready;
    assign cfg.ready  = 1'b1;

    ubds_walk #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .desc_in(desc.payload),
        .sum    (sum)
    );

    // report zero or an oversize packet as the cap
    function automatic logic [9:0] clamp_packet(input logic [15:0] p, input logic [9:0] cap);
        logic [9:0] r;
        if (p == 16'd0 || p > {6'd0, cap})
        begin
            r = cap;
        end
        else
        begin
            r = p[9:0];
        end
        return r;
    endfunction

    always_comb
    begin
        out_next              = '0;
        out_next.config_value = sum.config_value;
        if (!sum.header_ok)
        begin
            out_next.status = ST_NO_HEADER;
        end
        else if (!sum.found)
        begin
            out_next.status = ST_NO_INTERFACE;
        end
        else
        begin
            out_next.status              = ST_FOUND;
            out_next.bulk_in_endpoint    = sum.in_ep;
            out_next.bulk_out_endpoint   = sum.out_ep;
            out_next.bulk_in_max_packet  = clamp_packet(sum.in_pkt, cap_reg);
            out_next.bulk_out_max_packet = clamp_packet(sum.out_pkt, cap_reg);
        end

        // advance the result register when empty or drained this cycle
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || result.ready)
        begin
            out_valid_next = take && desc.payload.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.payload.max_packet_cap;
            end
        end
    end

    // payload: load only with a new result
    always_ff @(posedge clk)
    begin
        if (take && desc.payload.last_byte)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    `UBDS_ASSERT_IMPL(a_fail_fields_zero,
        out_valid_reg && out_reg.status != ST_FOUND,
        out_reg.bulk_in_endpoint == 4'd0 && out_reg.bulk_out_endpoint == 4'd0 &&
        out_reg.bulk_in_max_packet == 10'd0 && out_reg.bulk_out_max_packet == 10'd0,
        "failed scan reports nonzero endpoint fields")
    `UBDS_ASSERT_IMPL(a_found_has_endpoints,
        out_valid_reg && out_reg.status == ST_FOUND,
        out_reg.bulk_in_endpoint != 4'd0 && out_reg.bulk_out_endpoint != 4'd0,
        "found interface reports an absent endpoint")
    `UBDS_ASSERT_NEXT(a_last_gives_result,
        take && desc.payload.last_byte,
        out_valid_reg,
        "last byte transfer produced no result")

endmodule
